// ===== rtl/core/tpdl_pkg.sv =====
// tpdl_pkg: request/response types, band and power limits and anchor tables
// for the transmit power duty lookup
// depends on nothing
`default_nettype none

package tpdl_pkg;

    localparam int FREQ_W  = 32;
    localparam int POWER_W = 14;
    localparam int DUTY_W  = 7;
    localparam int SLOT_W  = 3;   // anchor slot within a band, 0..4
    localparam int PCLS_W  = 2;

    typedef struct packed {
        logic [FREQ_W-1:0]  frequency;
        logic [POWER_W-1:0] power_request;
    } req_t;

    typedef struct packed {
        logic              valid_res;
        logic              band_vhf;
        logic [DUTY_W-1:0] drive_duty;
    } rsp_t;

    // band edges, inclusive
    localparam logic [FREQ_W-1:0] VHF_LOW_HZ  = 32'd136000000;
    localparam logic [FREQ_W-1:0] VHF_HIGH_HZ = 32'd174000000;
    localparam logic [FREQ_W-1:0] UHF_LOW_HZ  = 32'd400000000;
    localparam logic [FREQ_W-1:0] UHF_HIGH_HZ = 32'd480000000;

    // power limits
    localparam logic [POWER_W-1:0] POWER_MAX_MW = 14'd5000;
    localparam logic [POWER_W-1:0] POWER_LOW_MW = 14'd1000;
    localparam logic [POWER_W-1:0] POWER_MID_MW = 14'd2500;

    // power classes
    localparam logic [PCLS_W-1:0] PCLS_LOW  = 2'd0;
    localparam logic [PCLS_W-1:0] PCLS_MID  = 2'd1;
    localparam logic [PCLS_W-1:0] PCLS_HIGH = 2'd2;

    // anchors: 136.125, 146.125, 156.125, 166.125, 173.975 MHz (vhf)
    //          400.125, 420.125, 440.125, 460.125, 479.975 MHz (uhf)
    // a frequency picks the upper of two neighbors only when it lies strictly
    // above floor((lo + hi) / 2), which keeps ties on the lower anchor
    localparam logic [FREQ_W-1:0] VHF_MID0 = 32'd141125000;
    localparam logic [FREQ_W-1:0] VHF_MID1 = 32'd151125000;
    localparam logic [FREQ_W-1:0] VHF_MID2 = 32'd161125000;
    localparam logic [FREQ_W-1:0] VHF_MID3 = 32'd170050000;
    localparam logic [FREQ_W-1:0] UHF_MID0 = 32'd410125000;
    localparam logic [FREQ_W-1:0] UHF_MID1 = 32'd430125000;
    localparam logic [FREQ_W-1:0] UHF_MID2 = 32'd450125000;
    localparam logic [FREQ_W-1:0] UHF_MID3 = 32'd470050000;

    // low power duty per anchor
    function automatic logic [DUTY_W-1:0] duty_a(input logic vhf, input logic [SLOT_W-1:0] slot);
        logic [DUTY_W-1:0] d;
        case ({vhf, slot})
            4'b1000: d = 7'd33;
            4'b1001: d = 7'd30;
            4'b1010: d = 7'd27;
            4'b1011: d = 7'd33;
            4'b1100: d = 7'd40;
            4'b0000: d = 7'd33;
            4'b0001: d = 7'd32;
            4'b0010: d = 7'd31;
            4'b0011: d = 7'd30;
            4'b0100: d = 7'd31;
            default: d = 7'd0;
        endcase
        return d;
    endfunction

    // high power duty per anchor
    function automatic logic [DUTY_W-1:0] duty_b(input logic vhf, input logic [SLOT_W-1:0] slot);
        logic [DUTY_W-1:0] d;
        case ({vhf, slot})
            4'b1000: d = 7'd67;
            4'b1001: d = 7'd57;
            4'b1010: d = 7'd64;
            4'b1011: d = 7'd73;
            4'b1100: d = 7'd74;
            4'b0000: d = 7'd75;
            4'b0001: d = 7'd74;
            4'b0010: d = 7'd74;
            4'b0011: d = 7'd76;
            4'b0100: d = 7'd75;
            default: d = 7'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tx_power_duty_lookup.sv =====
// tx_power_duty_lookup: three stage pipeline from frequency and power to drive duty
// depends on tpdl_pkg
`default_nettype none

// usage
//   request channel: req_valid / req_stall / req_data (frequency in Hz, power in mW)
//   response channel: rsp_valid / rsp_stall / rsp_data (valid_res, band_vhf, duty)
//   a transfer happens on a rising edge with valid high and stall low
//   every request gives exactly one response, in order
//   path: an accepted request is registered in stage 1, then stage 2, then
//     stage 3, whose valid register drives rsp_valid
//   throughput: one request per cycle while rsp_stall is low; one register level per stage
//     stage 1: power limit, power class and band range compares
//     stage 2: compare against the four band midpoints, nearest anchor slot
//     stage 3: anchor table read and duty select, response register
//   a rejected request (power 0, power above 5000 mW, frequency outside
//   both bands) still gives a response, with every field at zero
//   stall: each stage holds when the stage after it is full and stalled;
//   empty stages keep filling, so up to three requests sit inside while
//   rsp_stall is high, and req_stall rises only once all three are full
//   reset: rst_n low empties the pipeline at once; no request is lost or
//   replayed across a stall, and nothing leaves before it entered

module tx_power_duty_lookup (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire tpdl_pkg::req_t req_data,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output tpdl_pkg::rsp_t     rsp_data
);

    // stage enables: a stage loads when it is empty or its content moves on
    logic en1;
    logic en2;
    logic en3;

    // stage 1 registers
    logic                            v1_reg;
    logic [tpdl_pkg::FREQ_W-1:0]     freq1_reg;
    logic                            ok1_reg;
    logic                            vhf1_reg;
    logic [tpdl_pkg::PCLS_W-1:0]     pcls1_reg;

    // stage 2 registers
    logic                            v2_reg;
    logic                            ok2_reg;
    logic                            vhf2_reg;
    logic [tpdl_pkg::PCLS_W-1:0]     pcls2_reg;
    logic [tpdl_pkg::SLOT_W-1:0]     slot2_reg;

    // stage 3 registers
    logic                            v3_reg;
    tpdl_pkg::rsp_t                  rsp_reg;

    // stage 1 next values
    logic                            ok1_next;
    logic                            vhf1_next;
    logic [tpdl_pkg::PCLS_W-1:0]     pcls1_next;

    // stage 2 next value
    logic [tpdl_pkg::SLOT_W-1:0]     slot2_next;

    // stage 3 next value
    tpdl_pkg::rsp_t                  rsp_next;

    assign en3 = !v3_reg || !rsp_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign req_stall = !en1;
    assign rsp_valid = v3_reg;
    assign rsp_data  = rsp_reg;

    // stage 1: power limits, power class and band membership
    always_comb
    begin
        logic pwr_ok;
        logic in_vhf;
        logic in_uhf;
        pwr_ok = (req_data.power_request != '0)
              && (req_data.power_request <= tpdl_pkg::POWER_MAX_MW);
        in_vhf = (req_data.frequency >= tpdl_pkg::VHF_LOW_HZ)
              && (req_data.frequency <= tpdl_pkg::VHF_HIGH_HZ);
        in_uhf = (req_data.frequency >= tpdl_pkg::UHF_LOW_HZ)
              && (req_data.frequency <= tpdl_pkg::UHF_HIGH_HZ);
        ok1_next  = pwr_ok && (in_vhf || in_uhf);
        vhf1_next = in_vhf;
        if (req_data.power_request <= tpdl_pkg::POWER_LOW_MW)
        begin
            pcls1_next = tpdl_pkg::PCLS_LOW;
        end
        else if (req_data.power_request <= tpdl_pkg::POWER_MID_MW)
        begin
            pcls1_next = tpdl_pkg::PCLS_MID;
        end
        else
        begin
            pcls1_next = tpdl_pkg::PCLS_HIGH;
        end
    end

    // stage 2: slot is the number of midpoints the frequency lies above
    always_comb
    begin
        logic c0;
        logic c1;
        logic c2;
        logic c3;
        if (vhf1_reg)
        begin
            c0 = freq1_reg > tpdl_pkg::VHF_MID0;
            c1 = freq1_reg > tpdl_pkg::VHF_MID1;
            c2 = freq1_reg > tpdl_pkg::VHF_MID2;
            c3 = freq1_reg > tpdl_pkg::VHF_MID3;
        end
        else
        begin
            c0 = freq1_reg > tpdl_pkg::UHF_MID0;
            c1 = freq1_reg > tpdl_pkg::UHF_MID1;
            c2 = freq1_reg > tpdl_pkg::UHF_MID2;
            c3 = freq1_reg > tpdl_pkg::UHF_MID3;
        end
        slot2_next = {{(tpdl_pkg::SLOT_W-1){1'b0}}, c0}
                   + {{(tpdl_pkg::SLOT_W-1){1'b0}}, c1}
                   + {{(tpdl_pkg::SLOT_W-1){1'b0}}, c2}
                   + {{(tpdl_pkg::SLOT_W-1){1'b0}}, c3};
    end

    // stage 3: anchor duties and selection by power class
    always_comb
    begin
        logic [tpdl_pkg::DUTY_W-1:0] da;
        logic [tpdl_pkg::DUTY_W-1:0] db;
        logic [tpdl_pkg::DUTY_W:0]   sum;
        logic [tpdl_pkg::DUTY_W-1:0] duty;
        da  = tpdl_pkg::duty_a(vhf2_reg, slot2_reg);
        db  = tpdl_pkg::duty_b(vhf2_reg, slot2_reg);
        sum = {1'b0, da} + {1'b0, db};
        case (pcls2_reg)
            tpdl_pkg::PCLS_LOW:  duty = da;
            tpdl_pkg::PCLS_MID:  duty = sum[tpdl_pkg::DUTY_W:1];
            tpdl_pkg::PCLS_HIGH: duty = db;
            default:             duty = db;
        endcase
        if (ok2_reg)
        begin
            rsp_next.valid_res  = 1'b1;
            rsp_next.band_vhf   = vhf2_reg;
            rsp_next.drive_duty = duty;
        end
        else
        begin
            rsp_next.valid_res  = 1'b0;
            rsp_next.band_vhf   = 1'b0;
            rsp_next.drive_duty = '0;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= req_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            freq1_reg <= req_data.frequency;
            ok1_reg   <= ok1_next;
            vhf1_reg  <= vhf1_next;
            pcls1_reg <= pcls1_next;
        end
        if (en2)
        begin
            ok2_reg   <= ok1_reg;
            vhf2_reg  <= vhf1_reg;
            pcls2_reg <= pcls1_reg;
            slot2_reg <= slot2_next;
        end
        if (en3)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tpdl_checker.sv =====
// tpdl_checker: port level assertions for tx_power_duty_lookup, bound to the top level
// depends on tpdl_pkg
`default_nettype none

module tpdl_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire tpdl_pkg::req_t req_data,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire tpdl_pkg::rsp_t rsp_data
);

    // a stalled request holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_data))
        else $error("request changed while stalled");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // rejected responses carry zero fields, accepted ones a real duty
    a_rsp_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.valid_res
                       ? (rsp_data.drive_duty != '0 && rsp_data.drive_duty <= 7'd100)
                       : (!rsp_data.band_vhf && rsp_data.drive_duty == '0)))
        else $error("response fields inconsistent");

    // an empty output stage means the pipeline can take a request
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("request stalled with empty output");

    // with no downstream stall an accepted request shows up as rsp_valid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && !rsp_stall ##1 !rsp_stall ##1 !rsp_stall)
        |=> rsp_valid)
        else $error("response missing after pipeline latency");

endmodule

bind tx_power_duty_lookup tpdl_checker u_tpdl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/tb_tx_power_duty_lookup.sv =====
// tb_tx_power_duty_lookup: self-checking testbench for the transmit power duty lookup
// depends on tpdl_pkg and tx_power_duty_lookup
`timescale 1ns / 1ps

module tb_tx_power_duty_lookup;

    localparam int RAND_REQUESTS = 700;
    localparam int CALM_FROM     = 600;   // no idling on either side from here on
    localparam int HOLD_AT       = 200;   // request index that starts the long receiver hold
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 8;

    // one directed row: request, plus a typed-in response where it is obvious
    typedef struct packed {
        tpdl_pkg::req_t req;
        logic           typed;
        tpdl_pkg::rsp_t rsp;
    } probe_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    tpdl_pkg::req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    tpdl_pkg::rsp_t rsp_data;

    // calibration anchors, ascending: five vhf then five uhf
    logic [tpdl_pkg::FREQ_W-1:0] anchor_hz [10] = '{
        32'd136125000, 32'd146125000, 32'd156125000, 32'd166125000, 32'd173975000,
        32'd400125000, 32'd420125000, 32'd440125000, 32'd460125000, 32'd479975000
    };
    logic [tpdl_pkg::DUTY_W-1:0] anchor_low_duty [10] = '{
        7'd33, 7'd30, 7'd27, 7'd33, 7'd40, 7'd33, 7'd32, 7'd31, 7'd30, 7'd31
    };
    logic [tpdl_pkg::DUTY_W-1:0] anchor_high_duty [10] = '{
        7'd67, 7'd57, 7'd64, 7'd73, 7'd74, 7'd75, 7'd74, 7'd74, 7'd76, 7'd75
    };

    tpdl_pkg::rsp_t pending_duty [$];   // responses still owed by the block, oldest first
    probe_t         probes [$];

    int  errors = 0;
    int  sent = 0;
    int  got_accepted = 0;
    int  got_rejected = 0;
    int  got_vhf = 0;
    int  input_held = 0;        // cycles the block pushed back on an offered request
    bit  calm = 1'b0;           // final stretch, no idling at all
    bit  hold_now = 1'b0;       // asks the receiver for one long hold-off

    tx_power_duty_lookup u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always #2 clk = ~clk;

    // expected response: reject on bad power or out-of-band frequency,
    // otherwise nearest anchor in the band (ties go low) and a power-class duty
    function automatic tpdl_pkg::rsp_t predict_duty(input tpdl_pkg::req_t r);
        tpdl_pkg::rsp_t              o;
        logic                        vhf;
        int unsigned                 base;
        int unsigned                 best;
        int unsigned                 i;
        logic [tpdl_pkg::FREQ_W-1:0] best_gap;
        logic [tpdl_pkg::FREQ_W-1:0] d;
        logic [tpdl_pkg::DUTY_W:0]   duty_sum;
        o = '0;
        if (r.power_request == '0 || r.power_request > tpdl_pkg::POWER_MAX_MW)
            return o;
        if (r.frequency >= tpdl_pkg::VHF_LOW_HZ && r.frequency <= tpdl_pkg::VHF_HIGH_HZ)
            vhf = 1'b1;
        else if (r.frequency >= tpdl_pkg::UHF_LOW_HZ && r.frequency <= tpdl_pkg::UHF_HIGH_HZ)
            vhf = 1'b0;
        else
            return o;
        base = vhf ? 0 : 5;
        best = base;
        best_gap = '0;
        for (i = 0; i < 5; i++)
        begin
            d = (r.frequency > anchor_hz[base + i]) ? r.frequency - anchor_hz[base + i]
                                                    : anchor_hz[base + i] - r.frequency;
            // strict compare keeps the lower anchor on equal distance
            if (i == 0 || d < best_gap)
            begin
                best_gap = d;
                best = base + i;
            end
        end
        o.valid_res = 1'b1;
        o.band_vhf  = vhf;
        if (r.power_request <= tpdl_pkg::POWER_LOW_MW)
            o.drive_duty = anchor_low_duty[best];
        else if (r.power_request <= tpdl_pkg::POWER_MID_MW)
        begin
            duty_sum = {1'b0, anchor_low_duty[best]} + {1'b0, anchor_high_duty[best]};
            o.drive_duty = duty_sum[tpdl_pkg::DUTY_W:1];
        end
        else
            o.drive_duty = anchor_high_duty[best];
        return o;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic add_probe(input logic [tpdl_pkg::FREQ_W-1:0] f,
                             input logic [tpdl_pkg::POWER_W-1:0] p,
                             input logic typed, input tpdl_pkg::rsp_t r);
        probe_t pr;
        pr.req.frequency     = f;
        pr.req.power_request = p;
        pr.typed             = typed;
        pr.rsp               = typed ? r : '0;
        probes.push_back(pr);
    endtask

    // offer one request and hold it until the block takes it; the expected
    // response is queued at the accepting edge
    task automatic offer_request(input tpdl_pkg::req_t r, input tpdl_pkg::rsp_t e,
                                 input bit may_idle);
        if (may_idle && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_duty.push_back(e);
        sent++;
    endtask

    // response checker: every accepted response against the oldest expectation
    always @(posedge clk)
    begin
        tpdl_pkg::rsp_t e;
        if (rst_n && req_valid && req_stall)
            input_held++;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_duty.size() == 0)
                flag_mismatch($sformatf("response %p with nothing outstanding", rsp_data));
            else
            begin
                e = pending_duty.pop_front();
                if (rsp_data.valid_res !== e.valid_res)
                    flag_mismatch($sformatf("valid_res got %b want %b",
                                            rsp_data.valid_res, e.valid_res));
                if (rsp_data.band_vhf !== e.band_vhf)
                    flag_mismatch($sformatf("band_vhf got %b want %b",
                                            rsp_data.band_vhf, e.band_vhf));
                if (rsp_data.drive_duty !== e.drive_duty)
                    flag_mismatch($sformatf("drive_duty got %0d want %0d",
                                            rsp_data.drive_duty, e.drive_duty));
            end
            if (rsp_data.valid_res === 1'b1)
                got_accepted++;
            else
                got_rejected++;
            if (rsp_data.band_vhf === 1'b1)
                got_vhf++;
        end
    end

    // receiver: random stall bursts, one long hold-off on request, none when calm
    initial
    begin
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_now)
            begin
                // long hold so the pipeline fills and pushes back on requests
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_now = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                rsp_stall <= 1'b0;
                repeat (calm ? 1 : $urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("timeout with %0d responses outstanding", pending_duty.size());
        $display("Some tests failed");
        $finish;
    end

    // stimulus: directed table first, then random requests
    initial
    begin
        tpdl_pkg::req_t               r;
        tpdl_pkg::rsp_t               e;
        int unsigned                  n;
        int unsigned                  fsel;
        int unsigned                  psel;
        int unsigned                  k;
        logic [tpdl_pkg::FREQ_W-1:0]  f;
        logic [tpdl_pkg::POWER_W-1:0] p;

        // band edges, both sides of each
        add_probe(32'd136000000,     14'd1, 1'b1, '{1'b1, 1'b1, 7'd33});
        add_probe(32'd135999999,   14'd100, 1'b1, '0);
        add_probe(32'd174000000,  14'd5000, 1'b1, '{1'b1, 1'b1, 7'd74});
        add_probe(32'd174000001,   14'd100, 1'b1, '0);
        add_probe(32'd400000000,  14'd1000, 1'b1, '{1'b1, 1'b0, 7'd33});
        add_probe(32'd399999999,  14'd1000, 1'b1, '0);
        add_probe(32'd480000000,  14'd5000, 1'b1, '{1'b1, 1'b0, 7'd75});
        add_probe(32'd480000001,  14'd5000, 1'b1, '0);
        // field extremes and bad power
        add_probe(32'd0,              14'd0, 1'b1, '0);
        add_probe(32'hFFFF_FFFF,  14'd16383, 1'b1, '0);
        add_probe(32'h8000_0000,  14'd10922, 1'b1, '0);
        add_probe(32'd150000000,      14'd0, 1'b1, '0);
        add_probe(32'd150000000,   14'd5001, 1'b1, '0);
        // saturated power lies above the limit
        add_probe(32'd440000000,  14'd16383, 1'b1, '0);
        // equal distance between neighbors, and one hertz above
        add_probe(32'd141125000,  14'd1000, 1'b0, '0);
        add_probe(32'd141125001,  14'd1001, 1'b0, '0);
        add_probe(32'd170050000,  14'd2500, 1'b0, '0);
        add_probe(32'd170050001,  14'd2501, 1'b0, '0);
        add_probe(32'd410125000,  14'd1500, 1'b0, '0);
        add_probe(32'd430125001,  14'd4000, 1'b0, '0);
        add_probe(32'd470050000,  14'd2500, 1'b0, '0);
        add_probe(32'd470050001,  14'd3000, 1'b0, '0);
        // anchors themselves
        add_probe(32'd156125000,     14'd1, 1'b0, '0);
        add_probe(32'd460125000,  14'd5000, 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
        begin
            e = probes[i].typed ? probes[i].rsp : predict_duty(probes[i].req);
            offer_request(probes[i].req, e, 1'b1);
        end

        for (n = 0; n < RAND_REQUESTS; n++)
        begin
            if (n == HOLD_AT)
                hold_now = 1'b1;
            if (n == CALM_FROM)
                calm = 1'b1;

            // mostly in-band frequencies, with midpoint and edge neighborhoods
            fsel = $urandom_range(0, 9);
            case (fsel)
                0: f = $urandom;
                1, 2, 3: f = $urandom_range(tpdl_pkg::VHF_LOW_HZ, tpdl_pkg::VHF_HIGH_HZ);
                4, 5, 6: f = $urandom_range(tpdl_pkg::UHF_LOW_HZ, tpdl_pkg::UHF_HIGH_HZ);
                7:
                begin
                    k = $urandom_range(0, 7);
                    if (k >= 4)
                        k = k + 1;   // skip the pair that straddles the two bands
                    f = ((anchor_hz[k] + anchor_hz[k + 1]) >> 1) + $urandom_range(0, 4) - 2;
                end
                8:
                begin
                    case ($urandom_range(0, 3))
                        0: f = tpdl_pkg::VHF_LOW_HZ;
                        1: f = tpdl_pkg::VHF_HIGH_HZ;
                        2: f = tpdl_pkg::UHF_LOW_HZ;
                        default: f = tpdl_pkg::UHF_HIGH_HZ;
                    endcase
                    f = f + $urandom_range(0, 4) - 2;
                end
                default:
                    f = $urandom_range(0, 1)
                        ? $urandom_range(tpdl_pkg::VHF_HIGH_HZ + 1, tpdl_pkg::UHF_LOW_HZ - 1)
                        : $urandom_range(0, tpdl_pkg::VHF_LOW_HZ - 1);
            endcase

            // power spread over the three classes, the limits and the rejects
            psel = $urandom_range(0, 9);
            case (psel)
                0: p = 14'($urandom_range(0, 16383));
                1:
                begin
                    case ($urandom_range(0, 8))
                        0: p = 14'd0;
                        1: p = 14'd1;
                        2: p = tpdl_pkg::POWER_LOW_MW;
                        3: p = tpdl_pkg::POWER_LOW_MW + 14'd1;
                        4: p = tpdl_pkg::POWER_MID_MW;
                        5: p = tpdl_pkg::POWER_MID_MW + 14'd1;
                        6: p = tpdl_pkg::POWER_MAX_MW;
                        7: p = tpdl_pkg::POWER_MAX_MW + 14'd1;
                        default: p = 14'd16383;
                    endcase
                end
                2, 3: p = 14'($urandom_range(1, 1000));
                4, 5: p = 14'($urandom_range(1001, 2500));
                6, 7: p = 14'($urandom_range(2501, 5000));
                default: p = 14'($urandom_range(5001, 16383));
            endcase

            r.frequency     = f;
            r.power_request = p;
            offer_request(r, predict_duty(r), !calm);
        end

        req_valid <= 1'b0;
        while (pending_duty.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests: %0d accepted (%0d vhf), %0d rejected",
                 sent, got_accepted, got_vhf, got_rejected);
        $display("block pushed back on offered requests for %0d cycles", input_held);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
